>>> design/dsm_pkg.sv
// Package for the DFA string matcher: constants, payload and control types.
`default_nettype none
package dsm_pkg;
    localparam int BYTE_W          = 8;
    localparam int WORD_W          = 64;
    localparam int NUM_WORDS       = 4;
    localparam int BYTES_PER_WORD  = WORD_W / BYTE_W;
    localparam int PAT_BYTES       = NUM_WORDS * BYTES_PER_WORD;
    localparam int PAT_IDX_W       = $clog2(PAT_BYTES);
    localparam int LEN_W           = 6;
    localparam int CFG_IDX_W       = 3;
    localparam int MAX_PATTERN_DEF = 32;

    typedef logic [BYTE_W-1:0]    t_byte;
    typedef logic [WORD_W-1:0]    t_word;
    typedef logic [LEN_W-1:0]     t_len;
    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;

    localparam t_cfg_idx REG_WORD_0  = 3'd0;
    localparam t_cfg_idx REG_WORD_1  = 3'd1;
    localparam t_cfg_idx REG_WORD_2  = 3'd2;
    localparam t_cfg_idx REG_WORD_3  = 3'd3;
    localparam t_cfg_idx REG_LENGTH  = 3'd4;
    localparam t_len     LEN_RESET   = 6'd1;

    typedef struct packed {
        t_byte text_byte;
        logic  end_of_text;
    } t_in_word;

    typedef struct packed {
        logic match_here;
        logic found;
        logic text_done;
    } t_out_word;

    typedef struct packed {
        logic  en;
        logic  clr;
        t_byte data;
    } t_cell_ctrl;

    typedef enum logic [1:0] {
        ST_RUN    = 2'b01,
        ST_REPLAY = 2'b10
    } t_seq_state;
endpackage
`default_nettype wire

>>> design/dsm_cell.sv
// One prefix cell: holds whether the pattern prefix of its length ends the text.
`default_nettype none
module dsm_cell (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire dsm_pkg::t_cell_ctrl i_ctrl,
    input  wire dsm_pkg::t_byte     i_pat_byte,
    input  wire logic               i_prev,
    input  wire logic               i_active,
    output logic                    o_match,
    output logic                    o_hit_next
);
    import dsm_pkg::*;

    logic r_match;
    logic step_match;

    assign step_match = i_prev & i_active & (i_ctrl.data == i_pat_byte);
    assign o_hit_next = step_match;
    assign o_match    = r_match;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_match <= 1'b0;
        end else if (i_ctrl.clr) begin
            r_match <= 1'b0;
        end else if (i_ctrl.en) begin
            r_match <= step_match;
        end
    end
endmodule
`default_nettype wire

>>> design/dfa_string_matcher_top.sv
// Top level of the DFA string matcher: configuration, cell chain, replay and output stage.
//
// Text bytes enter at one word per cycle when not stalled; each gives one result word
// in the next cycle, held in an output register; the input stalls while a result waits.
// The matcher is a chain of MAX_PATTERN cells; cell k remembers whether the first k
// pattern bytes are the latest k text bytes, and all cells advance together on each
// byte, so the matched prefix length is the highest set cell. Every configuration
// write starts a replay: the chain is cleared and the first s pattern bytes are fed
// back through it, one per cycle, where s is the matched length before the write
// (capped at the pattern length); a further write restarts the replay. The input stalls
// during the write and until the replay after the last write has finished.
`default_nettype none
module dfa_string_matcher_top #(
    parameter int MAX_PATTERN = dsm_pkg::MAX_PATTERN_DEF
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    output logic                     o_in_stall,
    input  wire dsm_pkg::t_in_word   i_in_word,
    output logic                     o_out_valid,
    input  wire logic                i_out_stall,
    output dsm_pkg::t_out_word       o_out_word,
    input  wire logic                i_cfg_valid,
    output logic                     o_cfg_ready,
    input  wire dsm_pkg::t_cfg_idx   i_cfg_index,
    input  wire dsm_pkg::t_word      i_cfg_data
);
    import dsm_pkg::*;

    localparam t_len MAX_LEN = t_len'(MAX_PATTERN);

    t_word      r_pat_word [NUM_WORDS];
    t_len       r_len;
    t_seq_state r_state;
    t_seq_state n_state;
    t_len       r_cnt;
    t_len       n_cnt;
    t_len       r_hold;
    logic       r_found;
    logic       r_out_valid;
    t_out_word  r_out_word;

    t_byte      pat_byte [PAT_BYTES];
    t_len       eff_len;
    t_len       replay_len;
    t_len       next_len;
    logic       cfg_we;
    logic       in_accept;
    logic       replay_step;
    logic       hit;
    t_cell_ctrl ctrl;

    logic [MAX_PATTERN-1:0] cell_match;
    logic [MAX_PATTERN-1:0] cell_hit;
    logic [MAX_PATTERN-1:0] cell_prev;
    logic [MAX_PATTERN-1:0] cell_active;

    always_comb begin
        for (int w = 0; w < NUM_WORDS; w++) begin
            for (int b = 0; b < BYTES_PER_WORD; b++) begin
                pat_byte[w*BYTES_PER_WORD + b] = r_pat_word[w][b*BYTE_W +: BYTE_W];
            end
        end
    end

    always_comb begin
        if (r_len == '0) begin
            eff_len = t_len'(1);
        end else if (r_len > MAX_LEN) begin
            eff_len = MAX_LEN;
        end else begin
            eff_len = r_len;
        end
    end

    always_comb begin
        next_len = '0;
        for (int k = 0; k < MAX_PATTERN; k++) begin
            if (cell_hit[k]) begin
                next_len = t_len'(k + 1);
            end
        end
    end

    assign replay_len  = (r_hold < eff_len) ? r_hold : eff_len;
    assign o_cfg_ready = 1'b1;
    assign cfg_we      = i_cfg_valid & o_cfg_ready;
    assign o_in_stall  = (r_state != ST_RUN) | i_cfg_valid | (r_out_valid & i_out_stall);
    assign in_accept   = i_in_valid & ~o_in_stall;
    assign replay_step = (r_state == ST_REPLAY) & ~cfg_we & (r_cnt < replay_len);

    always_comb begin
        ctrl.en   = in_accept | replay_step;
        ctrl.clr  = cfg_we | (in_accept & i_in_word.end_of_text);
        ctrl.data = (r_state == ST_REPLAY) ? pat_byte[r_cnt[PAT_IDX_W-1:0]]
                                           : i_in_word.text_byte;
    end

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        case (r_state)
            ST_RUN: begin
                if (cfg_we) begin
                    n_state = ST_REPLAY;
                    n_cnt   = '0;
                end
            end
            ST_REPLAY: begin
                if (cfg_we) begin
                    n_cnt = '0;
                end else if (replay_step) begin
                    n_cnt = r_cnt + t_len'(1);
                end else begin
                    n_state = ST_RUN;
                end
            end
            default: begin
                n_state = ST_RUN;
                n_cnt   = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_RUN;
            r_cnt   <= '0;
            r_hold  <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            if (in_accept) begin
                r_hold <= i_in_word.end_of_text ? '0 : next_len;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int w = 0; w < NUM_WORDS; w++) begin
                r_pat_word[w] <= '0;
            end
            r_len <= LEN_RESET;
        end else if (cfg_we) begin
            case (i_cfg_index)
                REG_WORD_0: r_pat_word[0] <= i_cfg_data;
                REG_WORD_1: r_pat_word[1] <= i_cfg_data;
                REG_WORD_2: r_pat_word[2] <= i_cfg_data;
                REG_WORD_3: r_pat_word[3] <= i_cfg_data;
                REG_LENGTH: r_len <= i_cfg_data[LEN_W-1:0];
                default: begin
                end
            endcase
        end
    end

    genvar g;
    generate
        for (g = 0; g < MAX_PATTERN; g++) begin : g_cell
            if (g == 0) begin : g_head
                assign cell_prev[g] = 1'b1;
            end else begin : g_link
                assign cell_prev[g] = cell_match[g-1];
            end
            assign cell_active[g] = (t_len'(g + 1) <= eff_len);

            dsm_cell u_cell (
                .i_clk      (i_clk),
                .i_rst_n    (i_rst_n),
                .i_ctrl     (ctrl),
                .i_pat_byte (pat_byte[g]),
                .i_prev     (cell_prev[g]),
                .i_active   (cell_active[g]),
                .o_match    (cell_match[g]),
                .o_hit_next (cell_hit[g])
            );
        end
    endgenerate

    always_comb begin
        hit = 1'b0;
        for (int k = 0; k < MAX_PATTERN; k++) begin
            hit = hit | (cell_hit[k] & (eff_len == t_len'(k + 1)));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_found     <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (in_accept) begin
            r_found     <= ~i_in_word.end_of_text & (r_found | hit);
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_out_word.match_here <= hit;
            r_out_word.found      <= r_found | hit;
            r_out_word.text_done  <= i_in_word.end_of_text;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;
endmodule
`default_nettype wire

>>> design/dsm_checker.sv
// Port checker for the DFA string matcher and its bind to the top level.
`default_nettype none
module dsm_checker (
    input wire logic               i_clk,
    input wire logic               i_rst_n,
    input wire logic               i_in_valid,
    input wire logic               o_in_stall,
    input wire logic               o_out_valid,
    input wire logic               i_out_stall,
    input wire dsm_pkg::t_out_word o_out_word
);
    import dsm_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rst_n && o_out_valid && i_out_stall) |=> o_out_valid)
        else $error("result word dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rst_n && o_out_valid && i_out_stall) |=> $stable(o_out_word))
        else $error("stalled result word changed");

    a_match_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (!o_out_word.match_here || o_out_word.found))
        else $error("match without found flag");

    a_one_cycle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rst_n && i_in_valid && !o_in_stall) |=> o_out_valid)
        else $error("accepted byte gave no result next cycle");
endmodule

bind dfa_string_matcher_top dsm_checker u_dsm_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_word  (o_out_word)
);
`default_nettype wire
